>>> design/sacl_pkg.sv
// shared types and constants for the set-associative cache tag engine
// no dependencies
package sacl_pkg;
   localparam int SETS = 64;
   localparam int WAYS = 4;
   localparam int BLOCK_BYTES = 64;
   localparam int ADDR_BITS = 32;
   localparam int OFF_BITS = $clog2(BLOCK_BYTES);
   localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int SET_USED = $clog2(SETS);
   localparam int TAG_BITS = ADDR_BITS - OFF_BITS - SET_USED;
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int AGE_BITS = 8;
   localparam int CNT_BITS = 32;
   localparam int QDEPTH = 2;

   localparam logic [0:0] CSR_WRITE_BACK = 1'b0;
   localparam logic [0:0] CSR_WRITE_ALLOCATE = 1'b1;

   typedef struct packed {
      logic                is_write;
      logic [TAG_BITS-1:0] tag;
      logic [SET_BITS-1:0] set;
   } access_type;

   typedef struct packed {
      logic        hit;
      logic        fetch_read;
      logic        writeback_valid;
      logic [31:0] writeback_address;
      logic        forward_write;
      logic [31:0] read_accesses;
      logic [31:0] read_misses;
      logic [31:0] write_accesses;
      logic [31:0] write_misses;
   } result_type;
endpackage

>>> design/sacl_front.sv
// front end: accepts accesses, splits address into set and tag, queues them
// depends on sacl_pkg
module sacl_front import sacl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tuser,
   input  logic [31:0] req_tdata,
   output logic       q_valid,
   input  logic       q_pop,
   output access_type q_data
);
   localparam int PB = $clog2(QDEPTH);
   access_type mem_ff [QDEPTH];
   logic [PB-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PB:0]   cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] addr;
   access_type item;
   logic push;

   always_comb begin
      addr = ADDR_BITS'(req_tdata);
      item.is_write = req_tuser[0];
      item.set = SET_BITS'(addr >> OFF_BITS);
      item.tag = TAG_BITS'(addr >> (OFF_BITS + SET_USED));
      if (SETS == 1) item.set = '0;
   end

   assign req_tready = cnt_ff != (PB+1)'(QDEPTH);
   assign push = req_tvalid && req_tready;
   assign q_valid = cnt_ff != '0;
   assign q_data = mem_ff[rp_ff];
   assign wp_in = push ? wp_ff + 1'b1 : wp_ff;
   assign rp_in = q_pop ? rp_ff + 1'b1 : rp_ff;
   assign cnt_in = cnt_ff + (PB+1)'(push) - (PB+1)'(q_pop);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= item;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == (PB+1)'(QDEPTH) |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PB+1)'(QDEPTH)) else $error("queue count out of range");
`endif
endmodule

>>> design/sacl_back.sv
// back end: set lookup, victim choice, aging, counters, result register
// depends on sacl_pkg
module sacl_back import sacl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       write_back,
   input  logic       write_allocate,
   input  logic       q_valid,
   output logic       q_pop,
   input  access_type q_data,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_res
);
   typedef enum logic [1:0] {S_LOOK, S_DO, S_OUT} state_type;
   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [TAG_BITS-1:0] tag;
      logic [AGE_BITS-1:0] age;
   } line_type;
   typedef line_type [WAYS-1:0] row_type;

   row_type mem [SETS];
   logic [SETS-1:0] rv_ff;
   state_type st_ff;
   row_type rd_ff;
   access_type cur_ff;
   result_type res_ff;
   logic [CNT_BITS-1:0] rc_ff, rm_ff, wc_ff, wm_ff;
   row_type row, nrow;
   logic hit, fetch, wbv, fwd, any_inv;
   logic [WAY_BITS-1:0] hw, vw, tw, iw, bw;
   logic [AGE_BITS-1:0] ref_age;
   logic [31:0] wba;
   logic do_fill, mark;
   result_type res_in;

   function automatic logic [CNT_BITS-1:0] sat(input logic [CNT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // a set not written since reset reads as all zero
   assign row = rv_ff[cur_ff.set] ? rd_ff : '0;

   always_comb begin
      hit = 1'b0; hw = '0; any_inv = 1'b0; iw = '0; bw = '0;
      for (int i = WAYS-1; i >= 0; i--) begin
         if (row[i].valid && row[i].tag == cur_ff.tag) begin
            hit = 1'b1; hw = WAY_BITS'(i);
         end
         if (!row[i].valid) begin
            any_inv = 1'b1; iw = WAY_BITS'(i);
         end
      end
      for (int i = 1; i < WAYS; i++)
         if (row[i].age > row[bw].age) bw = WAY_BITS'(i);
      vw = any_inv ? iw : bw;
      do_fill = !hit && (!cur_ff.is_write || write_allocate);
      fetch = do_fill;
      wbv = do_fill && row[vw].valid && row[vw].dirty;
      wba = '0;
      if (wbv)
         wba = 32'((({(ADDR_BITS+SET_USED)'(row[vw].tag), SET_BITS'(cur_ff.set)}
                >> (SET_BITS - SET_USED)) << OFF_BITS));
      fwd = cur_ff.is_write && !write_back && (hit || !hit);
      if (cur_ff.is_write && !hit && !write_allocate) fwd = 1'b1;
      mark = cur_ff.is_write && write_back && (hit || do_fill);
      tw = hit ? hw : vw;
      ref_age = row[tw].age;
      nrow = row;
      if (hit || do_fill) begin
         for (int i = 0; i < WAYS; i++)
            if (row[i].age <= ref_age && row[i].age != '1)
               nrow[i].age = row[i].age + 1'b1;
         nrow[tw].age = '0;
         if (do_fill) begin
            nrow[tw].valid = 1'b1;
            nrow[tw].tag = cur_ff.tag;
            nrow[tw].dirty = 1'b0;
         end
         if (mark) nrow[tw].dirty = 1'b1;
      end
      res_in.hit = hit;
      res_in.fetch_read = fetch;
      res_in.writeback_valid = wbv;
      res_in.writeback_address = wba;
      res_in.forward_write = fwd;
      res_in.read_accesses = cur_ff.is_write ? rc_ff : sat(rc_ff);
      res_in.read_misses = (!cur_ff.is_write && !hit) ? sat(rm_ff) : rm_ff;
      res_in.write_accesses = cur_ff.is_write ? sat(wc_ff) : wc_ff;
      res_in.write_misses = (cur_ff.is_write && !hit) ? sat(wm_ff) : wm_ff;
   end

   assign q_pop = (st_ff == S_LOOK) && q_valid;
   assign rsp_tvalid = st_ff == S_OUT;
   assign rsp_res = res_ff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= mem[q_data.set];
         cur_ff <= q_data;
      end
      if (st_ff == S_DO) mem[cur_ff.set] <= nrow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOOK;
         rv_ff <= '0;
         rc_ff <= '0; rm_ff <= '0; wc_ff <= '0; wm_ff <= '0;
      end else begin
         case (st_ff)
            S_LOOK: if (q_valid) st_ff <= S_DO;
            S_DO: begin
               rv_ff[cur_ff.set] <= 1'b1;
               rc_ff <= res_in.read_accesses;
               rm_ff <= res_in.read_misses;
               wc_ff <= res_in.write_accesses;
               wm_ff <= res_in.write_misses;
               res_ff <= res_in;
               st_ff <= S_OUT;
            end
            S_OUT: if (rsp_tready) st_ff <= S_LOOK;
            default: st_ff <= S_LOOK;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_pop_only_look: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> st_ff == S_DO) else $error("pop without lookup");
   a_wb_needs_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_res.writeback_valid |-> rsp_res.fetch_read)
      else $error("writeback without fetch");
   a_hit_no_fetch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_res.hit |-> !rsp_res.fetch_read)
      else $error("fetch on hit");
`endif
endmodule

>>> design/set_assoc_cache_lru_controller_unit.sv
// set-associative cache tag engine, lru, write-back or write-through
// path from accept to result valid: queue write, queue pop with set read, update
// the back end takes a new item only once the last result is taken, after its set read,
// update and result hold steps; a 2-entry queue decouples the front
// reset: synchronous; sets read as invalid until touched, no clearing pass
module set_assoc_cache_lru_controller_unit import sacl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_write_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tuser,   // action
   input  logic [31:0] req_tdata,   // address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tuser,   // hit, fetch_read, writeback_valid, forward_write
   output logic [159:0] rsp_tdata   // writeback_address, read_accesses, read_misses,
                                    // write_accesses, write_misses
);
   logic wb_ff, wa_ff, q_valid, q_pop;
   access_type q_data;
   result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff <= 1'b1;
         wa_ff <= 1'b1;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_WRITE_BACK) wb_ff <= csr_write_data[0];
         if (csr_index == CSR_WRITE_ALLOCATE) wa_ff <= csr_write_data[0];
      end
   end

   sacl_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata), .q_valid(q_valid), .q_pop(q_pop),
      .q_data(q_data));

   sacl_back u_back (
      .clock(clock), .reset(reset), .write_back(wb_ff), .write_allocate(wa_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_res(res));

   assign rsp_tuser = {4'b0, res.forward_write, res.writeback_valid, res.fetch_read, res.hit};
   assign rsp_tdata = {res.write_misses, res.write_accesses, res.read_misses,
                       res.read_accesses, res.writeback_address};
endmodule

>>> tb/sv/set_assoc_cache_lru_controller_unit_test.sv
// self-checking testbench for the set-associative cache tag engine
// depends on sacl_pkg and set_assoc_cache_lru_controller_unit
`timescale 1ns / 100ps

module set_assoc_cache_lru_controller_unit_test;
   import sacl_pkg::*;

   localparam int READ_OP = 0;
   localparam int WRITE_OP = 1;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [0:0]  csr_write_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tuser;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tuser;
   logic [159:0] rsp_tdata;

   set_assoc_cache_lru_controller_unit dut (.*);

   // shadow of the cache state
   logic                valid_bits [SETS][WAYS];
   logic                dirty_bits [SETS][WAYS];
   logic [TAG_BITS-1:0] tag_store  [SETS][WAYS];
   logic [7:0]          age_store  [SETS][WAYS];
   logic [31:0] reads_seen, read_miss_seen, writes_seen, write_miss_seen;
   logic        mode_write_back, mode_write_allocate;

   result_type expected_results [$];
   int mismatches;
   int hold_off;

   typedef struct {
      logic        is_write;
      logic [31:0] address;
      bit          typed;
      logic        hit;
      logic        fetch_read;
      logic        writeback_valid;
      logic        forward_write;
   } access_row_type;

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
   endfunction

   function automatic void age_ways(int s, int w);
      logic [7:0] ref_age;
      ref_age = age_store[s][w];
      for (int i = 0; i < WAYS; i++)
         if (age_store[s][i] <= ref_age && age_store[s][i] != 8'hFF)
            age_store[s][i]++;
      age_store[s][w] = 0;
   endfunction

   function automatic result_type predict_access(logic is_write, logic [31:0] address);
      result_type r;
      int s, way, victim;
      logic [TAG_BITS-1:0] t;
      r = '0;
      s = (address >> OFF_BITS) % SETS;
      t = TAG_BITS'(address >> (OFF_BITS + SET_USED));
      way = -1;
      for (int i = 0; i < WAYS; i++)
         if (way < 0 && valid_bits[s][i] && tag_store[s][i] == t) way = i;
      if (way >= 0) begin
         r.hit = 1;
         age_ways(s, way);
      end
      if (!is_write) reads_seen = sat_inc(reads_seen);
      else writes_seen = sat_inc(writes_seen);
      if (is_write && way >= 0) begin
         if (mode_write_back) dirty_bits[s][way] = 1;
         else r.forward_write = 1;
      end else if (way < 0) begin
         if (!is_write) read_miss_seen = sat_inc(read_miss_seen);
         else write_miss_seen = sat_inc(write_miss_seen);
         if (is_write && !mode_write_allocate) begin
            r.forward_write = 1;
         end else begin
            victim = -1;
            for (int i = 0; i < WAYS; i++)
               if (victim < 0 && !valid_bits[s][i]) victim = i;
            if (victim < 0) begin
               victim = 0;
               for (int i = 1; i < WAYS; i++)
                  if (age_store[s][i] > age_store[s][victim]) victim = i;
            end
            r.fetch_read = 1;
            if (valid_bits[s][victim] && dirty_bits[s][victim]) begin
               r.writeback_valid = 1;
               r.writeback_address = 32'((64'(tag_store[s][victim]) << (OFF_BITS + SET_USED))
                                         | (64'(s) << OFF_BITS));
            end
            valid_bits[s][victim] = 1;
            tag_store[s][victim] = t;
            dirty_bits[s][victim] = 0;
            age_ways(s, victim);
            if (is_write) begin
               if (mode_write_back) dirty_bits[s][victim] = 1;
               else r.forward_write = 1;
            end
         end
      end
      r.read_accesses = reads_seen;
      r.read_misses = read_miss_seen;
      r.write_accesses = writes_seen;
      r.write_misses = write_miss_seen;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("set_assoc_cache_lru_controller_unit regression: fail");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      result_type got, want;
      int pause;
      rsp_tready = 0;
      mismatches = 0;
      hold_off = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if ($urandom_range(0, 1)) pause = 0;
         if (pause > 0) begin
            rsp_tready <= 0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock iff rsp_tvalid);
         got.hit = rsp_tuser[0];
         got.fetch_read = rsp_tuser[1];
         got.writeback_valid = rsp_tuser[2];
         got.forward_write = rsp_tuser[3];
         {got.write_misses, got.write_accesses, got.read_misses, got.read_accesses,
          got.writeback_address} = rsp_tdata;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   task automatic write_csr(logic [0:0] index, logic [0:0] value);
      csr_write_enable <= 1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      if (index == CSR_WRITE_BACK) mode_write_back = value;
      else mode_write_allocate = value;
   endtask

   task automatic drain_results();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // sends one item; when the row is typed the hand values override the predictor
   task automatic send_access(access_row_type row, bit idle_gaps);
      result_type r;
      int gap;
      gap = idle_gaps ? $urandom_range(0, 18) : 0;
      if (idle_gaps && $urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= {7'b0, row.is_write};
      req_tdata <= row.address;
      @(posedge clock iff req_tready);
      r = predict_access(row.is_write, row.address);
      if (row.typed && {r.hit, r.fetch_read, r.writeback_valid, r.forward_write} !==
          {row.hit, row.fetch_read, row.writeback_valid, row.forward_write})
         $display("table row disagrees with predictor at %h", row.address);
      if (row.typed) begin
         r.hit = row.hit;
         r.fetch_read = row.fetch_read;
         r.writeback_valid = row.writeback_valid;
         r.forward_write = row.forward_write;
      end
      expected_results.push_back(r);
   endtask

   function automatic logic [31:0] pick_address(int set_pick);
      logic [31:0] a;
      a = $urandom();
      // few tags per set so hits and evictions both happen
      a[OFF_BITS +: SET_USED] = SET_USED'(set_pick);
      a[31:OFF_BITS + SET_USED] = ($urandom_range(0, 3) == 0) ? a[31:OFF_BITS + SET_USED]
                                  : {4'($urandom_range(0, 5)), 16'h0} ^ {TAG_BITS{a[31]}};
      return a;
   endfunction

   initial begin
      access_row_type directed [] = '{
         '{READ_OP,  32'h0000_0000, 1, 0, 1, 0, 0},
         '{READ_OP,  32'h0000_003F, 1, 1, 0, 0, 0},
         '{WRITE_OP, 32'h0000_0010, 1, 1, 0, 0, 0},
         '{WRITE_OP, 32'h0001_0000, 1, 0, 1, 0, 0},
         '{READ_OP,  32'h0002_0000, 1, 0, 1, 0, 0},
         '{READ_OP,  32'h0003_0000, 1, 0, 1, 0, 0},
         '{READ_OP,  32'h0004_0000, 0, 0, 0, 0, 0},
         '{READ_OP,  32'h0005_0000, 0, 0, 0, 0, 0},
         '{WRITE_OP, 32'hFFFF_FFFF, 1, 0, 1, 0, 0},
         '{READ_OP,  32'hFFFF_FFC0, 1, 1, 0, 0, 0},
         '{READ_OP,  32'h0000_0FC0, 0, 0, 0, 0, 0},
         '{WRITE_OP, 32'h0000_0000, 0, 0, 0, 0, 0},
         '{READ_OP,  32'h0001_0040, 0, 0, 0, 0, 0}
      };
      access_row_type wt_rows [] = '{
         '{WRITE_OP, 32'h0000_0000, 0, 0, 0, 0, 0},
         '{WRITE_OP, 32'h7777_0080, 0, 0, 0, 0, 0},
         '{WRITE_OP, 32'h5555_0080, 0, 0, 0, 0, 0},
         '{READ_OP,  32'h7777_0080, 0, 0, 0, 0, 0}
      };
      access_row_type row;
      int timeout;
      reset = 1;
      csr_write_enable = 0;
      csr_index = '0;
      csr_write_data = '0;
      req_tvalid = 0;
      req_tuser = '0;
      req_tdata = '0;
      for (int s = 0; s < SETS; s++)
         for (int w = 0; w < WAYS; w++) begin
            valid_bits[s][w] = 0;
            dirty_bits[s][w] = 0;
            tag_store[s][w] = '0;
            age_store[s][w] = '0;
         end
      reads_seen = 0;
      read_miss_seen = 0;
      writes_seen = 0;
      write_miss_seen = 0;
      mode_write_back = 1;
      mode_write_allocate = 1;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) send_access(directed[i], 0);
      req_tvalid <= 0;
      drain_results();
      // every config setting, including write-through and no-allocate
      for (int m = 0; m < 4; m++) begin
         write_csr(CSR_WRITE_BACK, m[0]);
         write_csr(CSR_WRITE_ALLOCATE, m[1]);
         foreach (wt_rows[i]) send_access(wt_rows[i], 1);
         req_tvalid <= 0;
         drain_results();
      end

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_WRITE_BACK, (ph % 3 != 1));
         write_csr(CSR_WRITE_ALLOCATE, (ph % 3 != 2));
         if (ph == 2) hold_off = 300;
         for (int n = 0; n < 150; n++) begin
            row.is_write = 1'($urandom_range(0, 1));
            row.address = pick_address($urandom_range(0, 7) == 0 ? $urandom_range(0, SETS - 1)
                                       : $urandom_range(0, 3));
            row.typed = 0;
            send_access(row, !(ph == 2 || ph == 4));
            // sender waits for all outstanding results now and then
            if (n == 75) begin
               req_tvalid <= 0;
               drain_results();
            end
         end
         req_tvalid <= 0;
         drain_results();
      end

      timeout = 0;
      while (expected_results.size() != 0 && timeout < 20000) begin
         @(posedge clock);
         timeout++;
      end
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("set_assoc_cache_lru_controller_unit regression: pass");
      else
         $display("set_assoc_cache_lru_controller_unit regression: fail");
      $finish;
   end
endmodule

>>> sim.f
design/sacl_pkg.sv
design/sacl_front.sv
design/sacl_back.sv
design/set_assoc_cache_lru_controller_unit.sv
tb/sv/set_assoc_cache_lru_controller_unit_test.sv
